>>> design/ptd_pkg.sv
package ptd_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int LANE_MAX        = 16;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_BOX    = 3'd1,
        KIND_PLANE  = 3'd2,
        KIND_SPHERE = 3'd3,
        KIND_CYL    = 3'd4,
        KIND_CONE   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        REG_KIND      = 3'd0,
        REG_CORNER_A  = 3'd1,
        REG_CORNER_B  = 3'd2,
        REG_R_OUT     = 3'd3,
        REG_R_IN      = 3'd4,
        REG_INV_AX    = 3'd5,
        REG_PLANE_OFS = 3'd6
    } t_reg_idx;

    // per-request control traveling down the pipe
    typedef struct packed {
        logic       vld;
        logic [2:0] kind;
        logic       box;
        logic       plane;
        logic       sphere;
    } t_flags;

endpackage

>>> design/ptd_front.sv
module ptd_front import ptd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [15:0]        i_pos_x,
    input  logic [15:0]        i_pos_y,
    input  logic [15:0]        i_pos_z,
    input  logic [2:0]         i_kind,
    input  logic [47:0]        i_corner_a,
    input  logic [47:0]        i_corner_b,
    input  logic [15:0]        i_r_out,
    input  logic [15:0]        i_r_in,
    input  logic [31:0]        i_inv_ax,
    input  logic signed [31:0] i_plane_ofs,
    output t_flags             o_flags,
    output logic signed [16:0] o_x [3],
    output logic               o_neg,
    output logic [50:0]        o_hi,
    output logic [47:0]        o_lo,
    output logic [31:0]        o_ro_sq,
    output logic [31:0]        o_ri_sq
);

    localparam int LW = (COORD_WIDTH > LANE_MAX) ? LANE_MAX : COORD_WIDTH;

    logic [15:0]        w_pos [3];
    logic signed [15:0] w_p   [3];
    logic signed [15:0] w_a   [3];
    logic signed [15:0] w_b   [3];
    logic signed [16:0] w_x   [3];
    logic signed [31:0] w_pb  [3];
    logic [16:0]        w_mag [3];
    logic               w_box;
    logic signed [34:0] w_psum;
    logic signed [34:0] w_d;
    logic [35:0]        w_rsq;

    t_flags             r1_f, r2_f, r3_f;
    logic signed [16:0] r1_x [3];
    logic signed [16:0] r2_x [3];
    logic signed [16:0] r3_x [3];
    logic signed [31:0] r1_pb [3];
    logic signed [32:0] r2_d  [3];
    logic [33:0]        r2_sq [3];
    logic               r3_neg;
    logic [50:0]        r3_hi;
    logic [47:0]        r3_lo;
    logic [31:0]        r_ro_sq, r_ri_sq;

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_comb begin
        w_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            w_p[i]   = 16'($signed(w_pos[i][LW-1:0]));
            w_a[i]   = 16'($signed(i_corner_a[i*LW +: LW]));
            w_b[i]   = 16'($signed(i_corner_b[i*LW +: LW]));
            w_x[i]   = 17'(w_p[i]) - 17'(w_a[i]);
            w_pb[i]  = 32'(w_p[i]) * 32'(w_b[i]);
            w_mag[i] = r1_x[i][16] ? 17'(-r1_x[i]) : 17'(r1_x[i]);
            if (w_p[i] < w_a[i] || w_p[i] > w_b[i]) begin
                w_box = 1'b0;
            end
        end
        w_psum = 35'(r1_pb[0]) + 35'(r1_pb[1]) + 35'(r1_pb[2]) + 35'(i_plane_ofs);
        w_d    = 35'(r2_d[0]) + 35'(r2_d[1]) + 35'(r2_d[2]);
        w_rsq  = 36'(r2_sq[0]) + 36'(r2_sq[1]) + 36'(r2_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_f <= '0;
            r2_f <= '0;
            r3_f <= '0;
        end else if (i_en) begin
            r1_f <= '{vld: i_vld, kind: i_kind, box: w_box, plane: 1'b0, sphere: 1'b0};
            r2_f <= '{vld: r1_f.vld, kind: r1_f.kind, box: r1_f.box,
                      plane: ~w_psum[34], sphere: 1'b0};
            r3_f <= '{vld: r2_f.vld, kind: r2_f.kind, box: r2_f.box, plane: r2_f.plane,
                      sphere: (w_rsq <= 36'(r_ro_sq)) && (w_rsq >= 36'(r_ri_sq))};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ro_sq <= 32'(i_r_out) * 32'(i_r_out);
        r_ri_sq <= 32'(i_r_in) * 32'(i_r_in);
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_x[i]  <= w_x[i];
                r1_pb[i] <= w_pb[i];
                r2_x[i]  <= r1_x[i];
                r2_d[i]  <= 33'(w_b[i]) * 33'(r1_x[i]);
                r2_sq[i] <= 34'(w_mag[i]) * 34'(w_mag[i]);
                r3_x[i]  <= r2_x[i];
            end
            r3_neg <= w_d[34];
            r3_hi  <= 51'(w_d[34:16]) * 51'(i_inv_ax);
            r3_lo  <= 48'(w_d[15:0]) * 48'(i_inv_ax);
        end
    end

    assign o_flags = r3_f;
    assign o_x     = r3_x;
    assign o_neg   = r3_neg;
    assign o_hi    = r3_hi;
    assign o_lo    = r3_lo;
    assign o_ro_sq = r_ro_sq;
    assign o_ri_sq = r_ri_sq;

endmodule

>>> design/ptd_axial.sv
module ptd_axial import ptd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_flags             i_flags,
    input  logic signed [16:0] i_x [3],
    input  logic               i_neg,
    input  logic [50:0]        i_hi,
    input  logic [47:0]        i_lo,
    input  logic [47:0]        i_corner_b,
    input  logic [15:0]        i_r_out,
    input  logic [15:0]        i_r_in,
    output t_flags             o_flags,
    output logic               o_fail,
    output logic [53:0]        o_mm [3],
    output logic [49:0]        o_s1sq,
    output logic [49:0]        o_s2sq
);

    localparam int LW = (COORD_WIDTH > LANE_MAX) ? LANE_MAX : COORD_WIDTH;
    localparam logic [67:0] T_ONE = 68'(1) << 40;

    logic signed [15:0] w_b    [3];
    logic [67:0]        w_prod;
    logic signed [42:0] w_rad  [3];
    logic [42:0]        w_rmag [3];

    t_flags             r4_f, r5_f, r6_f, r7_f;
    logic               r4_fail, r5_fail, r6_fail, r7_fail;
    logic [24:0]        r4_t;
    logic signed [16:0] r4_x  [3];
    logic signed [16:0] r5_x  [3];
    logic signed [41:0] r5_axt [3];
    logic [40:0]        r5_tr1, r5_tr2;
    logic [26:0]        r6_m  [3];
    logic [24:0]        r6_s1, r6_s2;
    logic [53:0]        r7_mm [3];
    logic [49:0]        r7_s1sq, r7_s2sq;

    always_comb begin
        w_prod = (68'(i_hi) << 16) + 68'(i_lo);
        for (int i = 0; i < 3; i++) begin
            w_b[i]    = 16'($signed(i_corner_b[i*LW +: LW]));
            w_rad[i]  = (43'(r5_x[i]) <<< 24) - 43'(r5_axt[i]);
            w_rmag[i] = w_rad[i][42] ? 43'(-w_rad[i]) : 43'(w_rad[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_f <= '0;
            r5_f <= '0;
            r6_f <= '0;
            r7_f <= '0;
        end else if (i_en) begin
            r4_f <= i_flags;
            r5_f <= r4_f;
            r6_f <= r5_f;
            r7_f <= r6_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_fail <= i_neg || (w_prod > T_ONE);
            r4_t    <= w_prod[40:16];
            r5_fail <= r4_fail;
            r5_tr1  <= 41'(r4_t) * 41'(i_r_out);
            r5_tr2  <= 41'(r4_t) * 41'(i_r_in);
            r6_fail <= r5_fail;
            r6_s1   <= r5_tr1[40:16];
            r6_s2   <= r5_tr2[40:16];
            r7_fail <= r6_fail;
            r7_s1sq <= 50'(r6_s1) * 50'(r6_s1);
            r7_s2sq <= 50'(r6_s2) * 50'(r6_s2);
            for (int i = 0; i < 3; i++) begin
                r4_x[i]   <= i_x[i];
                r5_x[i]   <= r4_x[i];
                r5_axt[i] <= 42'(w_b[i]) * 42'($signed({1'b0, r4_t}));
                r6_m[i]   <= w_rmag[i][42:16];
                r7_mm[i]  <= 54'(r6_m[i]) * 54'(r6_m[i]);
            end
        end
    end

    assign o_flags = r7_f;
    assign o_fail  = r7_fail;
    assign o_mm    = r7_mm;
    assign o_s1sq  = r7_s1sq;
    assign o_s2sq  = r7_s2sq;

endmodule

>>> design/point_in_domain_test.sv
// Point-in-domain test: answers whether a signed Q8.8 point lies inside the
// configured box, plane half-space, spherical, cylindrical or conical shell.
// Input channel: i_in_valid / o_in_stall with i_pos_x, i_pos_y, i_pos_z.
// Output channel: o_out_valid / i_out_stall with o_inside_res, one result
// per request, in order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 kind, 1 corner_a, 2 corner_b, 3 outer radius, 4 inner radius,
// 5 inverse axis length squared, 6 plane offset). Write only while idle.
// Pipeline: seven arithmetic stages plus the output register between
// acceptance and the result, set by the axis projection multiply chain
// (dot, scale, radial offset, square).
// Throughput: one request per cycle while the output is not stalled.
// Reset clears all valid bits and the configuration registers to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_stall goes high; nothing is dropped or repeated.
module point_in_domain_test import ptd_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_pos_z,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_inside_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);

    logic [2:0]         r_kind;
    logic [47:0]        r_corner_a, r_corner_b;
    logic [15:0]        r_r_out, r_r_in;
    logic [31:0]        r_inv_ax;
    logic signed [31:0] r_plane_ofs;

    logic               w_en;
    t_flags             w_f3, w_f7;
    logic signed [16:0] w_x [3];
    logic               w_neg, w_fail;
    logic [50:0]        w_hi;
    logic [47:0]        w_lo;
    logic [31:0]        w_ro_sq, w_ri_sq;
    logic [53:0]        w_mm [3];
    logic [49:0]        w_s1sq, w_s2sq;
    logic [55:0]        w_rsq;
    logic               w_cyl, w_cone;
    logic               n_res;
    logic               r_out_vld, r_out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= '0;
            r_corner_a  <= '0;
            r_corner_b  <= '0;
            r_r_out     <= '0;
            r_r_in      <= '0;
            r_inv_ax    <= '0;
            r_plane_ofs <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_KIND:      r_kind      <= i_cfg_data[2:0];
                REG_CORNER_A:  r_corner_a  <= i_cfg_data;
                REG_CORNER_B:  r_corner_b  <= i_cfg_data;
                REG_R_OUT:     r_r_out     <= i_cfg_data[15:0];
                REG_R_IN:      r_r_in      <= i_cfg_data[15:0];
                REG_INV_AX:    r_inv_ax    <= i_cfg_data[31:0];
                REG_PLANE_OFS: r_plane_ofs <= $signed(i_cfg_data[31:0]);
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_out_vld & i_out_stall;
    assign w_en       = ~o_in_stall;

    ptd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (i_in_valid),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_kind      (r_kind),
        .i_corner_a  (r_corner_a),
        .i_corner_b  (r_corner_b),
        .i_r_out     (r_r_out),
        .i_r_in      (r_r_in),
        .i_inv_ax    (r_inv_ax),
        .i_plane_ofs (r_plane_ofs),
        .o_flags     (w_f3),
        .o_x         (w_x),
        .o_neg       (w_neg),
        .o_hi        (w_hi),
        .o_lo        (w_lo),
        .o_ro_sq     (w_ro_sq),
        .o_ri_sq     (w_ri_sq)
    );

    ptd_axial #(.COORD_WIDTH(COORD_WIDTH)) u_axial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_flags    (w_f3),
        .i_x        (w_x),
        .i_neg      (w_neg),
        .i_hi       (w_hi),
        .i_lo       (w_lo),
        .i_corner_b (r_corner_b),
        .i_r_out    (r_r_out),
        .i_r_in     (r_r_in),
        .o_flags    (w_f7),
        .o_fail     (w_fail),
        .o_mm       (w_mm),
        .o_s1sq     (w_s1sq),
        .o_s2sq     (w_s2sq)
    );

    always_comb begin
        w_rsq  = 56'(w_mm[0]) + 56'(w_mm[1]) + 56'(w_mm[2]);
        w_cyl  = ~w_fail && (w_rsq <= (56'(w_ro_sq) << 16)) && (w_rsq >= (56'(w_ri_sq) << 16));
        w_cone = ~w_fail && (w_rsq <= 56'(w_s1sq)) && (w_rsq >= 56'(w_s2sq));
        unique case (w_f7.kind)
            KIND_BOX:    n_res = w_f7.box;
            KIND_PLANE:  n_res = w_f7.plane;
            KIND_SPHERE: n_res = w_f7.sphere;
            KIND_CYL:    n_res = w_cyl;
            KIND_CONE:   n_res = w_cone;
            default:     n_res = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_f7.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_res <= n_res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_inside_res = r_out_res;

    a_last_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_f7.vld && !o_in_stall) |=> r_out_vld)
        else $error("pipeline result lost at output register");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_f7.vld && !o_in_stall) |=> !r_out_vld)
        else $error("output valid without a request in the last stage");

endmodule
